### rtl/aes_cbc_pkg.sv
// Shared types, constants and AES byte functions for the AES-128 CBC cipher.
// No dependencies; the controller, datapath, top module and testbench import this package.
`default_nettype none
package aes_cbc_pkg;

    localparam int BLK_W  = 128;
    localparam int HALF_W = 64;
    localparam int RND_W  = 4;
    localparam logic [RND_W-1:0] RND_FIRST = 4'd1;
    localparam logic [RND_W-1:0] RND_LAST  = 4'd10;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYX,
        ST_INIT,
        ST_ROUND,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic cap;      // capture input beat, load key into round key register
        logic kx_step;  // one forward key schedule step (decrypt key prep)
        logic rd_init;  // initial AddRoundKey
        logic rd_step;  // one cipher round
        logic fin;      // write result, update chain
    } t_cmd;

    typedef struct packed {
        logic dec;
        logic rk_ok;
        logic rnd_top;
        logic rnd_bot;
        logic res_free;
    } t_sts;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
        logic [7:0] c;
        unique case (r)
            4'd1:    c = 8'h01;
            4'd2:    c = 8'h02;
            4'd3:    c = 8'h04;
            4'd4:    c = 8'h08;
            4'd5:    c = 8'h10;
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h40;
            4'd8:    c = 8'h80;
            4'd9:    c = 8'h1b;
            4'd10:   c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] sub_rot(input logic [31:0] w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    // round key r-1 -> r
    function automatic logic [BLK_W-1:0] key_fwd(input logic [BLK_W-1:0] k,
                                                 input logic [7:0] rc);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rc, 24'h0};
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // round key r -> r-1
    function automatic logic [BLK_W-1:0] key_inv(input logic [BLK_W-1:0] k,
                                                 input logic [7:0] rc);
        logic [31:0] p0, p1, p2, p3;
        p3 = k[31:0] ^ k[63:32];
        p2 = k[63:32] ^ k[95:64];
        p1 = k[95:64] ^ k[127:96];
        p0 = k[127:96] ^ sub_rot(p3) ^ {rc, 24'h0};
        return {p0, p1, p2, p3};
    endfunction

    // byte 0 is the most significant byte
    function automatic logic [BLK_W-1:0] sub_shift(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127-8*(c*4+i) -: 8] = SBOX[s[127-8*((((c+i)%4)*4)+i) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] inv_shift_sub(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127-8*((((c+i)%4)*4)+i) -: 8] = INV_SBOX[s[127-8*(c*4+i) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] mix_cols(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    function automatic logic [7:0] gm9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction
    function automatic logic [7:0] gm11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction
    function automatic logic [7:0] gm13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction
    function automatic logic [7:0] gm14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [BLK_W-1:0] inv_mix_cols(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            t[127-32*c -: 8] = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
            t[119-32*c -: 8] = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3);
            t[111-32*c -: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3);
            t[103-32*c -: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/aes_cbc_blk_in_if.sv
// Input channel of the AES-128 CBC cipher: one 128-bit block per beat.
// No dependencies.
`default_nettype none
interface aes_cbc_blk_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;

    modport source(output valid, block_high, block_low, first_block, input ready);
    modport sink(input valid, block_high, block_low, first_block, output ready);
endinterface
`default_nettype wire

### rtl/aes_cbc_res_out_if.sv
// Result channel of the AES-128 CBC cipher: one 128-bit block per beat.
// No dependencies.
`default_nettype none
interface aes_cbc_res_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source(output valid, result_high, result_low, input ready);
    modport sink(input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

### rtl/aes_cbc_ctrl.sv
// Sequencer of the AES-128 CBC cipher: steps the datapath through key prep,
// rounds and result write. Depends on aes_cbc_pkg.
`default_nettype none
module aes_cbc_ctrl
    import aes_cbc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.dec && !i_sts.rk_ok) ? ST_KEYX : ST_INIT;
                end
            end
            ST_KEYX: begin
                if (i_sts.rnd_top) n_state = ST_INIT;
            end
            ST_INIT:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (i_sts.dec ? i_sts.rnd_bot : i_sts.rnd_top) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.res_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            ST_KEYX:  o_cmd.kx_step = 1'b1;
            ST_INIT:  o_cmd.rd_init = 1'b1;
            ST_ROUND: o_cmd.rd_step = 1'b1;
            ST_FIN:   o_cmd.fin     = i_sts.res_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/aes_cbc_dp.sv
// Datapath of the AES-128 CBC cipher: config registers, one AES round and one
// key schedule step per cycle, chain value and result register. Uses aes_cbc_pkg.
`default_nettype none
module aes_cbc_dp
    import aes_cbc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [HALF_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  wire [HALF_W-1:0]     i_blk_high,
    input  wire [HALF_W-1:0]     i_blk_low,
    input  wire                  i_first,
    input  wire                  i_res_ready,
    output logic                 o_res_valid,
    output logic [HALF_W-1:0]    o_res_high,
    output logic [HALF_W-1:0]    o_res_low
);

    logic [BLK_W-1:0] r_key, r_iv;
    logic             r_dec;
    logic [BLK_W-1:0] r_blk, r_chain, r_state, r_rk, r_rk_last, r_res;
    logic             r_rk_ok, r_res_vld;
    logic [RND_W-1:0] r_round;

    logic [BLK_W-1:0] n_rk_fwd, n_rk_inv, enc_ss, enc_nxt, dec_t, dec_nxt;
    logic [BLK_W-1:0] chain_use;

    assign n_rk_fwd = key_fwd(r_rk, rcon(r_round));
    assign n_rk_inv = key_inv(r_rk, rcon(r_round));
    assign enc_ss   = sub_shift(r_state);
    assign enc_nxt  = ((r_round == RND_LAST) ? enc_ss : mix_cols(enc_ss)) ^ n_rk_fwd;
    assign dec_t    = inv_shift_sub(r_state) ^ n_rk_inv;
    assign dec_nxt  = (r_round == RND_FIRST) ? dec_t : inv_mix_cols(dec_t);
    assign chain_use = r_chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_iv    <= '0;
            r_dec   <= 1'b0;
            r_rk_ok <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HI: begin
                    r_key[127:64] <= i_cfg_data;
                    r_rk_ok       <= 1'b0;
                end
                CFG_KEY_LO: begin
                    r_key[63:0] <= i_cfg_data;
                    r_rk_ok     <= 1'b0;
                end
                CFG_IV_HI: r_iv[127:64] <= i_cfg_data;
                CFG_IV_LO: r_iv[63:0]   <= i_cfg_data;
                CFG_DEC:   r_dec        <= i_cfg_data[0];
                default: ;
            endcase
        end else if (i_cmd.kx_step && r_round == RND_LAST) begin
            r_rk_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain   <= '0;
            r_round   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_round <= RND_FIRST;
                if (i_first) r_chain <= r_iv;
            end else if (i_cmd.kx_step) begin
                r_round <= r_round + 1'b1;
            end else if (i_cmd.rd_init) begin
                r_round <= r_dec ? RND_LAST : RND_FIRST;
            end else if (i_cmd.rd_step) begin
                r_round <= r_dec ? r_round - 1'b1 : r_round + 1'b1;
            end else if (i_cmd.fin) begin
                r_chain <= r_dec ? r_blk : r_state;
            end

            if (i_cmd.fin) begin
                r_res_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_blk <= {i_blk_high, i_blk_low};
            r_rk  <= r_key;
        end else if (i_cmd.kx_step) begin
            r_rk <= n_rk_fwd;
            if (r_round == RND_LAST) r_rk_last <= n_rk_fwd;
        end else if (i_cmd.rd_init) begin
            if (r_dec) begin
                r_state <= r_blk ^ r_rk_last;
                r_rk    <= r_rk_last;
            end else begin
                r_state <= r_blk ^ chain_use ^ r_key;
                r_rk    <= r_key;
            end
        end else if (i_cmd.rd_step) begin
            r_state <= r_dec ? dec_nxt : enc_nxt;
            r_rk    <= r_dec ? n_rk_inv : n_rk_fwd;
        end
        if (i_cmd.fin) begin
            r_res <= r_dec ? (r_state ^ r_chain) : r_state;
        end
    end

    assign o_sts.dec      = r_dec;
    assign o_sts.rk_ok    = r_rk_ok;
    assign o_sts.rnd_top  = (r_round == RND_LAST);
    assign o_sts.rnd_bot  = (r_round == RND_FIRST);
    assign o_sts.res_free = !r_res_vld || i_res_ready;

    assign o_res_valid = r_res_vld;
    assign o_res_high  = r_res[127:64];
    assign o_res_low   = r_res[63:0];

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (!r_res_vld || i_res_ready))
        else $error("result overwritten while still held");
    a_dec_key_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_init && r_dec) |-> r_rk_ok)
        else $error("decrypt started without last round key");
    a_kx_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.kx_step && r_round == RND_LAST) |=> r_rk_ok)
        else $error("key cache not marked after expansion");

endmodule
`default_nettype wire

### rtl/aes128_cbc_cipher.sv
// AES-128 CBC cipher, one 128-bit block per beat. Encryption steps each block
// through capture, initial key add, ten rounds of a single round unit with
// the key schedule run alongside it, and the result write, the chain value
// closing the loop to the next block. Decryption takes the same steps once
// the last round key is cached; the first block after a key write first runs
// the forward key expansion to rebuild it. A result sits in an output
// register, so the next block is taken while it waits; that block holds in
// its result write until the previous result beat has left. Depends on
// aes_cbc_pkg, the two channel interfaces, aes_cbc_ctrl and aes_cbc_dp.
`default_nettype none
module aes128_cbc_cipher
    import aes_cbc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [HALF_W-1:0]     i_cfg_data,
    aes_cbc_blk_in_if.sink       i_blk,
    aes_cbc_res_out_if.source    o_res
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_blk.ready = in_ready;

    aes_cbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_blk.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    aes_cbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_blk_high  (i_blk.block_high),
        .i_blk_low   (i_blk.block_low),
        .i_first     (i_blk.first_block),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_res_high  (o_res.result_high),
        .o_res_low   (o_res.result_low)
    );

endmodule
`default_nettype wire

### tb/tb_aes128_cbc_cipher.sv
// Testbench for the AES-128 CBC cipher: drives blocks, predicts results with
// its own AES-128 CBC model and checks every result beat in order.
// Depends on aes_cbc_pkg, the two channel interfaces and aes128_cbc_cipher.
`timescale 1ns / 100ps
`default_nettype none
module tb_aes128_cbc_cipher;
    import aes_cbc_pkg::*;

    typedef struct packed {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [HALF_W-1:0] i_cfg_data = '0;

    aes_cbc_blk_in_if blk_if();
    aes_cbc_res_out_if res_if();

    aes128_cbc_cipher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_blk(blk_if.sink), .o_res(res_if.source)
    );

    // model copy of registers and chain
    logic [127:0] mdl_key, mdl_iv, mdl_chain;
    logic mdl_dec;
    t_res cipher_q[$];
    int err_cnt = 0;
    int hold_cycles = 0;
    logic stall_en = 1'b1;
    logic [7:0] sb[256];
    logic [7:0] isb[256];

    initial begin
        blk_if.valid = 1'b0;
        blk_if.block_high = '0;
        blk_if.block_low = '0;
        blk_if.first_block = 1'b0;
        res_if.ready = 1'b0;
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_x2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_x2(a);
        end
        return acc;
    endfunction

    // S-boxes from the multiplicative inverse and the affine map
    task automatic build_sboxes();
        logic [7:0] inv, q;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            q = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sb[x] = q;
            isb[q] = x[7:0];
        end
    endtask

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int n);
        return s[127-8*n -: 8];
    endfunction

    function automatic void expand_keys(input logic [127:0] key,
                                        output logic [127:0] rk[11]);
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
                rc = gf_x2(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] enc_block(input logic [127:0] s,
                                               input logic [127:0] key);
        logic [127:0] rk[11];
        logic [127:0] t;
        logic [7:0] a[4];
        expand_keys(key, rk);
        s ^= rk[0];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(4*c+i) -: 8] = sb[byte_at(s, ((c+i)%4)*4+i)];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int i = 0; i < 4; i++) a[i] = byte_at(t, 4*c+i);
                    for (int i = 0; i < 4; i++)
                        s[127-8*(4*c+i) -: 8] = gf_mul(a[i], 8'h02)
                            ^ gf_mul(a[(i+1)%4], 8'h03) ^ a[(i+2)%4] ^ a[(i+3)%4];
                end
            end else begin
                s = t;
            end
            s ^= rk[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] dec_block(input logic [127:0] s,
                                               input logic [127:0] key);
        logic [127:0] rk[11];
        logic [127:0] t;
        logic [7:0] a[4];
        expand_keys(key, rk);
        s ^= rk[10];
        for (int r = 10; r >= 1; r--) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(((c+i)%4)*4+i) -: 8] = isb[byte_at(s, 4*c+i)];
            s = t ^ rk[r-1];
            if (r != 1) begin
                for (int c = 0; c < 4; c++) begin
                    for (int i = 0; i < 4; i++) a[i] = byte_at(s, 4*c+i);
                    for (int i = 0; i < 4; i++)
                        s[127-8*(4*c+i) -: 8] = gf_mul(a[i], 8'h0e)
                            ^ gf_mul(a[(i+1)%4], 8'h0b)
                            ^ gf_mul(a[(i+2)%4], 8'h0d) ^ gf_mul(a[(i+3)%4], 8'h09);
                end
            end
        end
        return s;
    endfunction

    function automatic t_res cbc_predict(input logic [127:0] blk, input logic first);
        logic [127:0] out;
        if (first) mdl_chain = mdl_iv;
        if (mdl_dec) begin
            out = dec_block(blk, mdl_key) ^ mdl_chain;
            mdl_chain = blk;
        end else begin
            out = enc_block(blk ^ mdl_chain, mdl_key);
            mdl_chain = out;
        end
        return '{res_hi: out[127:64], res_lo: out[63:0]};
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // the enable drops between writes, which keeps the enable edges apart
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            CFG_KEY_HI: mdl_key[127:64] = data;
            CFG_KEY_LO: mdl_key[63:0] = data;
            CFG_IV_HI:  mdl_iv[127:64] = data;
            CFG_IV_LO:  mdl_iv[63:0] = data;
            CFG_DEC:    mdl_dec = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [127:0] key, input logic [127:0] iv,
                              input logic dec);
        write_reg(CFG_KEY_HI, key[127:64]);
        write_reg(CFG_KEY_LO, key[63:0]);
        write_reg(CFG_IV_HI, iv[127:64]);
        write_reg(CFG_IV_LO, iv[63:0]);
        write_reg(CFG_DEC, {63'(0), dec});
    endtask

    // drop valid, drain, then settle before touching registers
    task automatic wait_idle();
        blk_if.valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // valid stays high after a beat; a gap in the next call, or wait_idle, drops it
    task automatic send_block(input logic [127:0] blk, input logic first, input logic gaps);
        int gap;
        gap = gaps ? rand_gap() : 0;
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_if.valid <= 1'b1;
        blk_if.block_high <= blk[127:64];
        blk_if.block_low <= blk[63:0];
        blk_if.first_block <= first;
        @(posedge i_clk);
        while (!blk_if.ready) @(posedge i_clk);
        cipher_q.push_back(cbc_predict(blk, first));
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // receiver: random stalls, or a long hold when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = stall_en ? rand_gap() : 0;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected result beat %h_%h", res_if.result_high, res_if.result_low);
                err_cnt++;
            end else begin
                exp_res = cipher_q.pop_front();
                if (res_if.result_high !== exp_res.res_hi) begin
                    $error("result_high expected %h actual %h", exp_res.res_hi,
                           res_if.result_high);
                    err_cnt++;
                end
                if (res_if.result_low !== exp_res.res_lo) begin
                    $error("result_low expected %h actual %h", exp_res.res_lo,
                           res_if.result_low);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_zero_key();
        // registers untouched: all-zero key, chain zero, first flag only on the last block
        send_block('0, 1'b0, 1'b0);
        send_block('1, 1'b0, 1'b0);
        send_block(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_known_vector();
        // FIPS-197 vector with zero IV, both directions
        set_config(128'h0001_0203_0405_0607_0809_0a0b_0c0d_0e0f, '0, 1'b0);
        send_block(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_DEC, 64'd1);
        send_block(128'h69c4_e0d8_6a7b_0430_d8cd_b780_70b4_c55a, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_extremes();
        set_config('1, '1, 1'b0);
        send_block('0, 1'b1, 1'b0);
        send_block('1, 1'b0, 1'b0);
        send_block(128'h8000_0000_0000_0001_8000_0000_0000_0001, 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_DEC, 64'hffff_ffff_ffff_fffe); // upper bits dropped: encrypt
        send_block('1, 1'b1, 1'b0);
        wait_idle();
        set_config('0, '1, 1'b1);
        send_block('1, 1'b1, 1'b0);
        send_block('0, 1'b0, 1'b0);
        wait_idle();
        // unused register indexes have no effect
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        send_block(rand128(), 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_direction_switch();
        set_config(rand128(), rand128(), 1'b0);
        send_block(rand128(), 1'b1, 1'b0);
        send_block(rand128(), 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_DEC, 64'd1); // chain carries across
        send_block(rand128(), 1'b0, 1'b0);
        send_block(rand128(), 1'b0, 1'b0);
        wait_idle();
        write_reg(CFG_DEC, 64'd0);
        send_block(rand128(), 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 20; i++) send_block(rand128(), i == 0, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 1500) begin
            if ($urandom_range(0, 2) == 0) begin
                set_config(rand128(), rand128(), 1'($urandom_range(0, 1)));
            end else begin
                write_reg(CFG_DEC, {63'(0), 1'($urandom_range(0, 1))});
            end
            stall_en = $urandom_range(0, 3) != 0;
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                // mostly proper messages, now and then a stray first flag
                send_block(rand128(), i == 0 || $urandom_range(0, 30) == 0,
                           $urandom_range(0, 3) != 0);
            end
            sent += len;
            wait_idle();
        end
        stall_en = 1'b1;
    endtask

    initial begin
        mdl_key = '0;
        mdl_iv = '0;
        mdl_chain = '0;
        mdl_dec = 1'b0;
        build_sboxes();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_key();
        test_known_vector();
        test_extremes();
        test_direction_switch();
        test_backpressure();
        test_random_messages();
        wait_idle();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
